[sv/lr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types, codes and helpers of the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_W = 10;
  localparam int ERR_W   = 11;
  localparam int COLOR_W = 16;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ERR_W-1:0]   err_t;
  typedef logic [COLOR_W-1:0] color_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd3
  } dir_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t abs_dx;
    coord_t abs_dy;
    coord_t major_len;
    dir_t   dir_x;
    dir_t   dir_y;
  } line_setup_t;

  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    err_t   err_x;
    err_t   err_y;
  } walk_t;

  function automatic coord_t move_pos(input coord_t pos, input dir_t dir);
    case (dir)
      DIR_POS: move_pos = pos + coord_t'(1);
      DIR_NEG: move_pos = pos - coord_t'(1);
      default: move_pos = pos;
    endcase
  endfunction

endpackage

[sv/lr_setup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_setup
// Clamp endpoints to the screen, derive deltas, directions and major length.
// ----------------------------------------------------------------------------
module lr_setup import lr_pkg::*; #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 480
) (
  input  coord_t      x_start,
  input  coord_t      y_start,
  input  coord_t      x_end,
  input  coord_t      y_end,
  output line_setup_t setup
);

  localparam coord_t X_TOP = coord_t'(SCREEN_WIDTH - 1);
  localparam coord_t Y_TOP = coord_t'(SCREEN_HEIGHT - 1);

  coord_t xs, ys, xe, ye;

  always_comb begin
    xs = (x_start > X_TOP) ? X_TOP : x_start;
    ys = (y_start > Y_TOP) ? Y_TOP : y_start;
    xe = (x_end > X_TOP) ? X_TOP : x_end;
    ye = (y_end > Y_TOP) ? Y_TOP : y_end;

    setup.x0 = xs;
    setup.y0 = ys;

    if (xe > xs) begin
      setup.abs_dx = xe - xs;
      setup.dir_x  = DIR_POS;
    end else if (xe < xs) begin
      setup.abs_dx = xs - xe;
      setup.dir_x  = DIR_NEG;
    end else begin
      setup.abs_dx = '0;
      setup.dir_x  = DIR_NONE;
    end

    if (ye > ys) begin
      setup.abs_dy = ye - ys;
      setup.dir_y  = DIR_POS;
    end else if (ye < ys) begin
      setup.abs_dy = ys - ye;
      setup.dir_y  = DIR_NEG;
    end else begin
      setup.abs_dy = '0;
      setup.dir_y  = DIR_NONE;
    end

    setup.major_len = (setup.abs_dx > setup.abs_dy) ? setup.abs_dx : setup.abs_dy;
  end

endmodule

[sv/lr_stepper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_stepper
// Advance the error accumulators and position by one pixel.
// ----------------------------------------------------------------------------
module lr_stepper import lr_pkg::*; (
  input  line_setup_t line_cfg,
  input  walk_t       walk,
  output walk_t       walk_nxt
);

  err_t sum_x, sum_y, major_e;

  always_comb begin
    major_e = {1'b0, line_cfg.major_len};
    sum_x   = walk.err_x + {1'b0, line_cfg.abs_dx};
    sum_y   = walk.err_y + {1'b0, line_cfg.abs_dy};

    walk_nxt = walk;
    walk_nxt.err_x = sum_x;
    walk_nxt.err_y = sum_y;
    if (sum_x > major_e) begin
      walk_nxt.err_x = sum_x - major_e;
      walk_nxt.cur_x = move_pos(walk.cur_x, line_cfg.dir_x);
    end
    if (sum_y > major_e) begin
      walk_nxt.err_y = sum_y - major_e;
      walk_nxt.cur_y = move_pos(walk.cur_y, line_cfg.dir_y);
    end
  end

endmodule

[sv/line_rasterizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_core
// DDA line rasterizer: start words set up a line, step words emit pixels.
// ----------------------------------------------------------------------------
// Input channel in_*: in_tuser is the command (0 start, 1 step). A start word
// carries both endpoints and a color; endpoints are clamped to the screen and
// nothing is emitted. Each step word while a line is active emits one pixel on
// out_*, with out_tlast on the final pixel; a line gives major length + 1
// pixels. A step word while idle is consumed and dropped. A start word while a
// line is active abandons it.
// Latency: a pixel appears in the output register the cycle after its step
// word is taken. Throughput: one word per cycle, set by the single output
// register; in_tready is high whenever that register is empty or is being
// drained, so a stall on out_tready holds the pixel and backs up the input.
// Reset (rst_n low, synchronous) clears the active flag and the output valid.
// ----------------------------------------------------------------------------
module line_rasterizer_core import lr_pkg::*; #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x_start[9:0], y_start[19:10], x_end[29:20], y_end[39:30], color[55:40]
  input  logic [55:0] in_tdata,
  // command[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_x[9:0], pixel_y[19:10], pixel_color[35:20], zero[39:36]
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  line_setup_t setup_w, line_r;
  walk_t       walk_r, walk_w;
  err_t        points_left_r;
  logic        busy_r;
  color_t      color_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic        out_last_r;
  logic        accept, emit;

  lr_setup #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_setup (
    .x_start(in_tdata[9:0]),
    .y_start(in_tdata[19:10]),
    .x_end  (in_tdata[29:20]),
    .y_end  (in_tdata[39:30]),
    .setup  (setup_w)
  );

  lr_stepper u_stepper (
    .line_cfg(line_r),
    .walk    (walk_r),
    .walk_nxt(walk_w)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign emit      = accept && (in_tuser == CMD_STEP) && busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && (in_tuser == CMD_START)) begin
        busy_r <= 1'b1;
      end else if (emit && (points_left_r == err_t'(1))) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_tuser == CMD_START)) begin
      line_r        <= setup_w;
      color_r       <= in_tdata[55:40];
      walk_r.cur_x  <= setup_w.x0;
      walk_r.cur_y  <= setup_w.y0;
      walk_r.err_x  <= '0;
      walk_r.err_y  <= '0;
      points_left_r <= {1'b0, setup_w.major_len} + err_t'(1);
    end else if (emit) begin
      walk_r        <= walk_w;
      points_left_r <= points_left_r - err_t'(1);
      out_data_r    <= {4'b0, color_r, walk_r.cur_y, walk_r.cur_x};
      out_last_r    <= (points_left_r == err_t'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
